FILE: hdl/ubft_pkg.sv
package ubft_pkg;

    localparam int unsigned FRAME_SYMBOLS = 1 + 2 + 8 + 2 + 1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd12;
    localparam logic [5:0] BURSTS_RESET      = 6'd40;
    localparam logic [7:0] GAP_RESET         = 8'd10;

    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_BURSTS      = 2'd1;
    localparam logic [1:0] REG_GAP         = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic drive_a;
        logic drive_b;
        logic busy_res;
        logic frame_done;
        logic start_rejected;
    } t_out_word;

    // Start, two ones, data LSB first, pair parity low bit first, closing one.
    function automatic logic [FRAME_SYMBOLS-1:0] build_frame(input logic [7:0] data);
        logic [1:0] pair;
        pair = data[1:0] ^ data[3:2] ^ data[5:4] ^ data[7:6];
        return {1'b1, pair[1], pair[0], data, 2'b11, 1'b0};
    endfunction

endpackage

FILE: hdl/ultrasonic_burst_frame_transmitter_core.sv
// Channel   Ports                               Word
// input     i_in_valid, o_in_stall, i_in_data   t_in_word  (kind, data_byte)
// output    o_out_valid, i_out_stall, o_out_data t_out_word (drive levels, flags)
// config    i_cfg_we, i_cfg_index, i_cfg_data   8-bit write, no read-back
//
// Every input word yields one output word, which appears in the cycle after it is accepted.
// A word is accepted in every cycle unless the output register is full and stalled,
// so the sustained rate is one word per cycle, set by the single output register.
// Reset (synchronous, active low) restores the default timing registers and idles
// the sender. A stall on the output holds the result and stalls the input.
module ultrasonic_burst_frame_transmitter_core
    import ubft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_half_period;
    logic [5:0] r_bursts;
    logic [7:0] r_gap;

    logic [FRAME_SYMBOLS-1:0] r_frame_bits, n_frame_bits;
    logic [3:0] r_symbol_index, n_symbol_index;
    logic [5:0] r_burst_count, n_burst_count;
    logic       r_half_phase, n_half_phase;
    logic [7:0] r_tick_count, n_tick_count;
    logic       r_in_gap, n_in_gap;
    logic       r_active, n_active;

    logic      r_out_valid;
    t_out_word r_out, n_out;
    logic      accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [3:0]  sym_next;
        logic [7:0]  tick_next;
        logic [5:0]  burst_next;
        logic [15:0] frame_ext;
        logic        end_sym;
        logic        cur_bit;

        n_frame_bits   = r_frame_bits;
        n_symbol_index = r_symbol_index;
        n_burst_count  = r_burst_count;
        n_half_phase   = r_half_phase;
        n_tick_count   = r_tick_count;
        n_in_gap       = r_in_gap;
        n_active       = r_active;

        sym_next   = r_symbol_index + 4'd1;
        tick_next  = r_tick_count + 8'd1;
        burst_next = r_burst_count + 6'd1;
        frame_ext  = {{(16 - FRAME_SYMBOLS){1'b0}}, r_frame_bits};
        cur_bit    = frame_ext[r_symbol_index];
        end_sym    = 1'b0;

        n_out.drive_a        = 1'b1;
        n_out.drive_b        = 1'b0;
        n_out.busy_res       = 1'b0;
        n_out.frame_done     = 1'b0;
        n_out.start_rejected = 1'b0;

        if (r_active && !r_in_gap && !r_half_phase) begin
            n_out.drive_a = 1'b0;
            n_out.drive_b = 1'b1;
        end

        if (i_in_data.kind == KIND_START) begin
            n_out.busy_res = 1'b1;
            if (r_active) begin
                n_out.start_rejected = 1'b1;
            end else begin
                n_frame_bits   = build_frame(i_in_data.data_byte);
                n_symbol_index = '0;
                n_burst_count  = '0;
                n_half_phase   = 1'b0;
                n_tick_count   = '0;
                n_in_gap       = 1'b0;
                n_active       = 1'b1;
            end
        end else if (r_active) begin
            n_out.busy_res = 1'b1;
            n_tick_count   = tick_next;
            if (r_in_gap) begin
                end_sym = (tick_next >= r_gap);
            end else if (tick_next >= r_half_period) begin
                n_tick_count = '0;
                if (!r_half_phase) begin
                    n_half_phase = 1'b1;
                end else begin
                    n_half_phase  = 1'b0;
                    n_burst_count = burst_next;
                    if (burst_next >= r_bursts) begin
                        n_burst_count = '0;
                        if (cur_bit && r_gap != 8'd0) begin
                            n_in_gap = 1'b1;
                        end else begin
                            end_sym = 1'b1;
                        end
                    end
                end
            end

            if (end_sym) begin
                n_in_gap       = 1'b0;
                n_tick_count   = '0;
                n_burst_count  = '0;
                n_half_phase   = 1'b0;
                n_symbol_index = sym_next;
                if (sym_next >= 4'(FRAME_SYMBOLS)) begin
                    n_symbol_index   = '0;
                    n_active         = 1'b0;
                    n_out.frame_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period  <= HALF_PERIOD_RESET;
            r_bursts       <= BURSTS_RESET;
            r_gap          <= GAP_RESET;
            r_frame_bits   <= '0;
            r_symbol_index <= '0;
            r_burst_count  <= '0;
            r_half_phase   <= 1'b0;
            r_tick_count   <= '0;
            r_in_gap       <= 1'b0;
            r_active       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HALF_PERIOD: r_half_period <= i_cfg_data;
                    REG_BURSTS:      r_bursts      <= i_cfg_data[5:0];
                    REG_GAP:         r_gap         <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_frame_bits   <= n_frame_bits;
                r_symbol_index <= n_symbol_index;
                r_burst_count  <= n_burst_count;
                r_half_phase   <= n_half_phase;
                r_tick_count   <= n_tick_count;
                r_in_gap       <= n_in_gap;
                r_active       <= n_active;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result word needs no reset; its valid flag guards it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ubft_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = REG_HALF_PERIOD;
    logic [7:0] i_cfg_data = '0;

    // Copy of the timing registers and the sender state, updated as registers are written and words are accepted.
    logic [7:0]               cfg_half;
    logic [5:0]               cfg_bursts;
    logic [7:0]               cfg_gap;
    logic [FRAME_SYMBOLS-1:0] tx_symbols;
    logic [3:0]               tx_sym;
    logic [5:0]               tx_burst;
    logic                     tx_phase;
    logic [7:0]               tx_ticks;
    logic                     tx_in_gap;
    logic                     tx_active;

    t_out_word pending_words[$];
    int        fail_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;

    ultrasonic_burst_frame_transmitter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [FRAME_SYMBOLS-1:0] frame_for_byte(logic [7:0] data);
        logic [FRAME_SYMBOLS-1:0] f;
        logic [1:0]               par;
        par = 2'b00;
        for (int i = 0; i < 4; i++) begin
            par = par ^ data[2*i +: 2];
        end
        f = '0;
        f[1] = 1'b1;
        f[2] = 1'b1;
        for (int i = 0; i < 8; i++) begin
            f[3 + i] = data[i];
        end
        f[11] = par[0];
        f[12] = par[1];
        f[13] = 1'b1;
        return f;
    endfunction

    // Moves to the next symbol and returns 1 when the closing symbol has ended.
    function automatic logic next_symbol();
        tx_in_gap = 1'b0;
        tx_ticks  = '0;
        tx_burst  = '0;
        tx_phase  = 1'b0;
        tx_sym    = tx_sym + 4'd1;
        if (tx_sym >= FRAME_SYMBOLS) begin
            tx_sym    = '0;
            tx_active = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_word predict_levels(t_in_word w);
        t_out_word r;
        r = '0;
        r.drive_a = 1'b1;
        // Levels reflect the phase held before this word takes effect.
        if (tx_active && !tx_in_gap && !tx_phase) begin
            r.drive_a = 1'b0;
            r.drive_b = 1'b1;
        end
        if (w.kind == KIND_START) begin
            r.busy_res = 1'b1;
            if (tx_active) begin
                r.start_rejected = 1'b1;
            end else begin
                tx_symbols = frame_for_byte(w.data_byte);
                tx_sym     = '0;
                tx_burst   = '0;
                tx_phase   = 1'b0;
                tx_ticks   = '0;
                tx_in_gap  = 1'b0;
                tx_active  = 1'b1;
            end
        end else if (tx_active) begin
            r.busy_res = 1'b1;
            tx_ticks = tx_ticks + 8'd1;
            if (tx_in_gap) begin
                if (tx_ticks >= cfg_gap) r.frame_done = next_symbol();
            end else if (tx_ticks >= cfg_half) begin
                tx_ticks = '0;
                if (!tx_phase) begin
                    tx_phase = 1'b1;
                end else begin
                    tx_phase = 1'b0;
                    tx_burst = tx_burst + 6'd1;
                    if (tx_burst >= cfg_bursts) begin
                        tx_burst = '0;
                        if (tx_symbols[tx_sym] && cfg_gap != 8'd0) tx_in_gap = 1'b1;
                        else r.frame_done = next_symbol();
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic want, logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("result word with no expectation waiting: %b", o_out_data);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                check_field("drive_a", want.drive_a, o_out_data.drive_a);
                check_field("drive_b", want.drive_b, o_out_data.drive_b);
                check_field("busy_res", want.busy_res, o_out_data.busy_res);
                check_field("frame_done", want.frame_done, o_out_data.frame_done);
                check_field("start_rejected", want.start_rejected, o_out_data.start_rejected);
            end
        end
    end

    // Output stalls come in random bursts, and only while idle_on is set.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[ultrasonic_burst_frame_transmitter_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] data);
        t_in_word w;
        w.kind      = kind;
        w.data_byte = data;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_words.push_back(predict_levels(w));
    endtask

    task automatic send_tick();
        send_word(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            REG_HALF_PERIOD: cfg_half = value;
            REG_BURSTS:      cfg_bursts = value[5:0];
            REG_GAP:         cfg_gap = value;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_to_end();
        while (tx_active) send_tick();
    endtask

    // Defaults, a rejected start, registers cleared mid-frame, zero-valued registers
    // and a start sent right behind another start, which is rejected.
    task automatic test_directed();
        send_word(KIND_TICK, 8'h00);
        send_word(KIND_TICK, 8'hFF);
        send_word(KIND_START, 8'hFF);
        repeat (3) send_tick();
        send_word(KIND_START, 8'h00);
        write_reg(REG_HALF_PERIOD, 8'h00);
        write_reg(REG_BURSTS, 8'h00);
        write_reg(REG_GAP, 8'h00);
        run_to_end();
        send_word(KIND_START, 8'h00);
        send_word(KIND_START, 8'h5A);
        run_to_end();
        send_tick();
    endtask

    // Largest register values, then lowered while a burst half and a gap are running.
    task automatic test_register_extremes();
        write_reg(REG_HALF_PERIOD, 8'hFF);
        write_reg(REG_BURSTS, 8'hFF);
        write_reg(REG_GAP, 8'hFF);
        send_word(KIND_START, 8'($urandom_range(0, 255)));
        repeat (520) send_tick();
        write_reg(REG_HALF_PERIOD, 8'h01);
        write_reg(REG_BURSTS, 8'h01);
        repeat (300) send_tick();
        write_reg(REG_GAP, 8'h00);
        run_to_end();
    endtask

    task automatic test_random();
        int sent;
        int chunk;
        sent = 0;
        while (sent < 760) begin
            if (sent >= 570) idle_on = 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_HALF_PERIOD, 8'($urandom_range(0, 255)));
                write_reg(REG_BURSTS, 8'($urandom_range(0, 255)));
                write_reg(REG_GAP, 8'($urandom_range(0, 255)));
            end else begin
                write_reg(REG_HALF_PERIOD, 8'($urandom_range(0, 3)));
                // Upper bits of the write are outside the six-bit register.
                write_reg(REG_BURSTS, {2'($urandom_range(0, 3)), 6'($urandom_range(0, 3))});
                write_reg(REG_GAP, 8'($urandom_range(0, 4)));
            end
            chunk = $urandom_range(20, 120);
            repeat (chunk) begin
                if (!tx_active && $urandom_range(0, 2) == 0)
                    send_word(KIND_START, 8'($urandom_range(0, 255)));
                else if (tx_active && $urandom_range(0, 40) == 0)
                    send_word(KIND_START, 8'($urandom_range(0, 255)));
                else
                    send_tick();
                sent++;
            end
        end
    endtask

    initial begin
        cfg_half   = HALF_PERIOD_RESET;
        cfg_bursts = BURSTS_RESET;
        cfg_gap    = GAP_RESET;
        tx_symbols = '0;
        tx_sym     = '0;
        tx_burst   = '0;
        tx_phase   = 1'b0;
        tx_ticks   = '0;
        tx_in_gap  = 1'b0;
        tx_active  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("%0d expected result words never arrived", pending_words.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ultrasonic_burst_frame_transmitter_core] OK");
        end else begin
            $display("[ultrasonic_burst_frame_transmitter_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: ultrasonic_burst_frame_transmitter_core.f
hdl/ubft_pkg.sv
hdl/ultrasonic_burst_frame_transmitter_core.sv
test/tb_top.sv
